>>> rtl/core/polyline_store_arc_length_point_unit_defines.svh
// Assertion macros shared by the polyline store RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef POLYLINE_STORE_ARC_LENGTH_POINT_UNIT_DEFINES_SVH
`define POLYLINE_STORE_ARC_LENGTH_POINT_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define PSALP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define PSALP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/psalp_pkg.sv
// Shared types and constants for the polyline store.
// No dependencies.
`timescale 1ns / 1ps

package psalp_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_SET    = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_READ   = 3'd4,
    ACT_HEAD   = 3'd5,
    ACT_TAIL   = 3'd6,
    ACT_QUERY  = 3'd7
  } psalp_act_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 33;          // magnitude of a coordinate difference
  localparam int ROOT_W  = 34;          // segment length, unsigned integer (Q34.0)
  localparam int RAD_W   = 66;          // sum of squares
  localparam int PROD_W  = MAG_W + ROOT_W;
  localparam int LEN_W   = 42;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } psalp_ustat_t;

endpackage

>>> rtl/core/psalp_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on psalp_pkg.
`timescale 1ns / 1ps

module psalp_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [psalp_pkg::MAG_W-1:0]       a,
  input  logic [psalp_pkg::ROOT_W-1:0]      b,
  output psalp_pkg::psalp_ustat_t           st,
  output logic [psalp_pkg::PROD_W-1:0]      prod
);
  import psalp_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [PROD_W-1:0] mcand_r, mcand_nxt, prod_r, prod_nxt;
  logic [ROOT_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    mcand_nxt  = mcand_r;
    prod_nxt   = prod_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      mcand_nxt  = PROD_W'(a);
      mplier_nxt = b;
      prod_nxt   = '0;
      cnt_nxt    = CNT_W'(ROOT_W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) prod_nxt = prod_r + mcand_r;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign prod    = prod_r;

endmodule

>>> rtl/core/psalp_sqrt.sv
// Restoring integer square root, one root bit per cycle.
// Depends on psalp_pkg.
`timescale 1ns / 1ps

module psalp_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psalp_pkg::RAD_W-1:0]   rad,
  output psalp_pkg::psalp_ustat_t       st,
  output logic [psalp_pkg::ROOT_W-1:0]  root
);
  import psalp_pkg::*;

  localparam int STEPS = RAD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_s, trial;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  assign rem_s = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (rem_s >= trial) begin
        rem_nxt  = rem_s - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_s;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign root    = root_r;

endmodule

>>> rtl/core/psalp_div.sv
// Restoring divider, one quotient bit per cycle; quotient fits MAG_W bits.
// Depends on psalp_pkg.
`timescale 1ns / 1ps

module psalp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psalp_pkg::PROD_W-1:0]  num,
  input  logic [psalp_pkg::ROOT_W-1:0]  den,
  output psalp_pkg::psalp_ustat_t       st,
  output logic [psalp_pkg::MAG_W-1:0]   quo
);
  import psalp_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] num_r, num_nxt;   // dividend shifts out, quotient shifts in
  logic [ROOT_W-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [ROOT_W:0]   rem_s;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt, qbit;

  assign rem_s = {rem_r, num_r[PROD_W-1]};
  assign qbit  = rem_s >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? ROOT_W'(rem_s - {1'b0, den_r}) : rem_s[ROOT_W-1:0];
      num_nxt = {num_r[PROD_W-2:0], qbit};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quo     = num_r[MAG_W-1:0];

endmodule

>>> rtl/core/polyline_store_arc_length_point_unit.sv
// Polyline store with arc-length point lookup. One item at a time.
// Read/head/tail do one memory read; insert/remove first move each later point one place over
// with a read and a write; every accepted edit then walks all segments (two squares on the shared
// multiplier, then a root). A percent query walks up to the hit segment, then interpolates with
// a multiply and a divide per axis. A new item is taken only once the last result is registered.
// Reset (synchronous, rst_n low) empties the store and zeroes the length; no clearing pass.
`timescale 1ns / 1ps
`include "polyline_store_arc_length_point_unit_defines.svh"

module polyline_store_arc_length_point_unit #(
  parameter int CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  // in_tdata: index[7:0], x_in[39:8], y_in[71:40], fraction[87:72]
  input  logic [87:0]   in_tdata,
  // in_tuser: action[2:0]
  input  logic [2:0]    in_tuser,
  input  logic          in_tvalid,
  output logic          in_tready,
  // out_tdata: point_x[31:0], point_y[63:32], start_x[95:64], start_y[127:96],
  //            end_x[159:128], end_y[191:160], total_length[233:192], point_count[242:234]
  output logic [247:0]  out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]    out_tuser,
  output logic          out_tvalid,
  input  logic          out_tready
);
  import psalp_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam int ACCW = LEN_W + 1;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_DISP    = 20'h00002,
    S_MV_RD   = 20'h00004,
    S_MV_WR   = 20'h00008,
    S_PUT     = 20'h00010,
    S_RD      = 20'h00020,
    S_RD_CAP  = 20'h00040,
    S_WALK    = 20'h00080,
    S_W_FIRST = 20'h00100,
    S_W_CAP0  = 20'h00200,
    S_W_NEXT  = 20'h00400,
    S_W_CAP   = 20'h00800,
    S_W_SQX   = 20'h01000,
    S_W_SQY   = 20'h02000,
    S_W_ROOT  = 20'h04000,
    S_L_MX    = 20'h08000,
    S_L_DX    = 20'h10000,
    S_L_MY    = 20'h20000,
    S_L_DY    = 20'h40000,
    S_OUT     = 20'h80000
  } state_t;

  // Point memory: x in the low word, y in the high word. Undefined until written.
  logic [63:0] mem [CAPACITY];
  logic [63:0] rdata_r;
  logic        rd_en, we;
  logic [AW-1:0] rd_addr, waddr;
  logic [63:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Control and working registers
  state_t               state_r, state_nxt;
  psalp_act_t           act_r, act_nxt;
  logic [CMPW-1:0]      idx_r, idx_nxt;
  logic [63:0]          pt_r, pt_nxt;
  logic [15:0]          frac_r, frac_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt, mv_r, mv_nxt, seg_r, seg_nxt;
  logic [LEN_W-1:0]     sum_r, sum_nxt, tgt_r, tgt_nxt;
  logic [ACCW-1:0]      acc_r, acc_nxt;
  logic [63:0]          prev_r, prev_nxt, cur_r, cur_nxt, sqx_r, sqx_nxt;
  logic [MAG_W-1:0]     adx_r, adx_nxt, ady_r, ady_nxt;
  logic                 dxneg_r, dxneg_nxt, dyneg_r, dyneg_nxt;
  logic [ROOT_W-1:0]    dis_r, dis_nxt, t_r, t_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [COORD_W-1:0]   px_r, px_nxt, py_r, py_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [COORD_W-1:0]   ex_r, ex_nxt, ey_r, ey_nxt;
  logic [247:0]         otd_r, otd_nxt;
  logic [1:0]           otu_r, otu_nxt;
  logic                 ov_r, ov_nxt;

  // Shared arithmetic units
  logic                 mul_start, sqrt_start, div_start;
  logic [MAG_W-1:0]     mul_a;
  logic [ROOT_W-1:0]    mul_b;
  logic [PROD_W-1:0]    mul_prod;
  logic [ROOT_W-1:0]    root;
  logic [MAG_W-1:0]     quo;
  psalp_ustat_t         mul_st, sqrt_st, div_st;

  psalp_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                   .st(mul_st), .prod(mul_prod));
  psalp_sqrt u_sqrt (.clk, .rst_n, .start(sqrt_start),
                     .rad(RAD_W'(sqx_r) + RAD_W'(mul_prod[63:0])),
                     .st(sqrt_st), .root(root));
  psalp_div u_div (.clk, .rst_n, .start(div_start), .num(mul_prod), .den(dis_r),
                   .st(div_st), .quo(quo));

  // Differences of the freshly read point against the previous one
  logic signed [MAG_W-1:0] dx_c, dy_c;
  logic [MAG_W-1:0]        adx_c, ady_c;
  assign dx_c  = $signed({rdata_r[31], rdata_r[31:0]}) - $signed({prev_r[31], prev_r[31:0]});
  assign dy_c  = $signed({rdata_r[63], rdata_r[63:32]}) - $signed({prev_r[63], prev_r[63:32]});
  assign adx_c = dx_c[MAG_W-1] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
  assign ady_c = dy_c[MAG_W-1] ? MAG_W'(-dy_c) : MAG_W'(dy_c);

  // Segment search
  logic [ACCW:0]     acc_dis_c;
  logic [ACCW-1:0]   t_c;
  logic              hit_c, last_c, is_q;
  assign is_q      = (act_r == ACT_QUERY);
  assign acc_dis_c = (ACCW+1)'(acc_r) + (ACCW+1)'(root);
  assign hit_c     = is_q && (ACCW'(tgt_r) >= acc_r) && ((ACCW+1)'(tgt_r) <= acc_dis_c);
  assign t_c       = ACCW'(tgt_r) - acc_r;
  assign last_c    = ((CW+1)'(seg_r) + (CW+1)'(2)) == (CW+1)'(cnt_r);

  logic idx_ok, full, mv_more;
  logic [CW-1:0] mv_dec, mv_inc;
  assign idx_ok = idx_r < CMPW'(cnt_r);
  assign full   = cnt_r == CW'(CAPACITY);
  assign mv_dec = mv_r - CW'(1);
  assign mv_inc = mv_r + CW'(1);
  assign mv_more = (act_r == ACT_REMOVE) ? ((CW+1)'(mv_r) + (CW+1)'(1) < (CW+1)'(cnt_r))
                                         : (CMPW'(mv_r) > idx_r);

  logic accept, out_load;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!ov_r || out_tready);

  always_comb begin
    state_nxt = state_r;  act_nxt = act_r;   idx_nxt = idx_r;   pt_nxt = pt_r;
    frac_nxt = frac_r;    cnt_nxt = cnt_r;   mv_nxt = mv_r;     seg_nxt = seg_r;
    sum_nxt = sum_r;      tgt_nxt = tgt_r;   acc_nxt = acc_r;   prev_nxt = prev_r;
    cur_nxt = cur_r;      sqx_nxt = sqx_r;   adx_nxt = adx_r;   ady_nxt = ady_r;
    dxneg_nxt = dxneg_r;  dyneg_nxt = dyneg_r; dis_nxt = dis_r; t_nxt = t_r;
    status_nxt = status_r; px_nxt = px_r;    py_nxt = py_r;     sx_nxt = sx_r;
    sy_nxt = sy_r;        ex_nxt = ex_r;     ey_nxt = ey_r;
    otd_nxt = otd_r;      otu_nxt = otu_r;   ov_nxt = ov_r;
    rd_en = 1'b0;  rd_addr = '0;  we = 1'b0;  waddr = '0;  wdata = pt_r;
    mul_start = 1'b0;  mul_a = '0;  mul_b = '0;  sqrt_start = 1'b0;  div_start = 1'b0;

    // Drop the result once the sink takes it
    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt    = psalp_act_t'(in_tuser);
          idx_nxt    = CMPW'(in_tdata[7:0]);
          pt_nxt     = {in_tdata[71:40], in_tdata[39:8]};
          frac_nxt   = in_tdata[87:72];
          status_nxt = ST_OK;
          px_nxt = '0; py_nxt = '0; sx_nxt = '0; sy_nxt = '0; ex_nxt = '0; ey_nxt = '0;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (act_r)
          ACT_APPEND: begin
            if (full) begin
              status_nxt = ST_FULL; state_nxt = S_OUT;
            end else begin
              state_nxt = S_PUT;
            end
          end
          ACT_INSERT: begin
            if (!idx_ok) begin
              status_nxt = ST_BAD; state_nxt = S_OUT;
            end else if (full) begin
              status_nxt = ST_FULL; state_nxt = S_OUT;
            end else begin
              mv_nxt = cnt_r; state_nxt = S_MV_RD;
            end
          end
          ACT_SET: begin
            if (!idx_ok) begin
              status_nxt = ST_BAD; state_nxt = S_OUT;
            end else begin
              state_nxt = S_PUT;
            end
          end
          ACT_REMOVE: begin
            if (!idx_ok) begin
              status_nxt = ST_BAD; state_nxt = S_OUT;
            end else begin
              mv_nxt = idx_r[CW-1:0]; state_nxt = S_MV_RD;
            end
          end
          ACT_READ, ACT_HEAD, ACT_TAIL: begin
            mv_nxt = (act_r == ACT_READ) ? idx_r[CW-1:0] :
                     (act_r == ACT_HEAD) ? '0 : cnt_r - CW'(1);
            if ((act_r == ACT_READ) ? !idx_ok : (cnt_r == '0)) begin
              status_nxt = ST_BAD; state_nxt = S_OUT;
            end else begin
              state_nxt = S_RD;
            end
          end
          default: begin
            if ((CW+1)'(cnt_r) < (CW+1)'(2)) begin
              status_nxt = ST_BAD; state_nxt = S_OUT;
            end else begin
              tgt_nxt   = LEN_W'((LEN_W+16)'(sum_r) * (LEN_W+16)'(frac_r) >> 16);
              state_nxt = S_WALK;
            end
          end
        endcase
      end
      // Move loop: read one neighbor, write it one place over, advance
      S_MV_RD: begin
        if (mv_more) begin
          rd_en     = 1'b1;
          rd_addr   = (act_r == ACT_REMOVE) ? mv_inc[AW-1:0] : mv_dec[AW-1:0];
          state_nxt = S_MV_WR;
        end else if (act_r == ACT_REMOVE) begin
          cnt_nxt = cnt_r - CW'(1); state_nxt = S_WALK;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_MV_WR: begin
        we        = 1'b1;
        waddr     = mv_r[AW-1:0];
        wdata     = rdata_r;
        mv_nxt    = (act_r == ACT_REMOVE) ? mv_inc : mv_dec;
        state_nxt = S_MV_RD;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = (act_r == ACT_APPEND) ? cnt_r[AW-1:0] : idx_r[AW-1:0];
        if (act_r != ACT_SET) cnt_nxt = cnt_r + CW'(1);
        state_nxt = S_WALK;
      end
      S_RD: begin
        rd_en = 1'b1; rd_addr = mv_r[AW-1:0]; state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        px_nxt = rdata_r[31:0]; py_nxt = rdata_r[63:32]; state_nxt = S_OUT;
      end
      // Segment walk, shared by length recompute and the percent query
      S_WALK: begin
        seg_nxt = '0;
        acc_nxt = '0;
        if ((CW+1)'(cnt_r) < (CW+1)'(2)) begin
          sum_nxt = '0; state_nxt = S_OUT;
        end else begin
          state_nxt = S_W_FIRST;
        end
      end
      S_W_FIRST: begin
        rd_en = 1'b1; rd_addr = '0; state_nxt = S_W_CAP0;
      end
      S_W_CAP0: begin
        prev_nxt = rdata_r; state_nxt = S_W_NEXT;
      end
      S_W_NEXT: begin
        rd_en = 1'b1; rd_addr = AW'(seg_r + CW'(1)); state_nxt = S_W_CAP;
      end
      S_W_CAP: begin
        cur_nxt   = rdata_r;
        adx_nxt   = adx_c;
        ady_nxt   = ady_c;
        dxneg_nxt = dx_c[MAG_W-1];
        dyneg_nxt = dy_c[MAG_W-1];
        mul_start = 1'b1; mul_a = adx_c; mul_b = ROOT_W'(adx_c);
        state_nxt = S_W_SQX;
      end
      S_W_SQX: begin
        if (mul_st.done) begin
          sqx_nxt   = mul_prod[63:0];
          mul_start = 1'b1; mul_a = ady_r; mul_b = ROOT_W'(ady_r);
          state_nxt = S_W_SQY;
        end
      end
      S_W_SQY: begin
        if (mul_st.done) begin
          sqrt_start = 1'b1; state_nxt = S_W_ROOT;
        end
      end
      S_W_ROOT: begin
        if (sqrt_st.done) begin
          dis_nxt = root;
          if (hit_c) begin
            sx_nxt = prev_r[31:0]; sy_nxt = prev_r[63:32];
            ex_nxt = cur_r[31:0];  ey_nxt = cur_r[63:32];
            if (root == '0) begin
              // Zero-length segment: report its start
              px_nxt = prev_r[31:0]; py_nxt = prev_r[63:32];
              state_nxt = S_OUT;
            end else begin
              t_nxt     = t_c[ROOT_W-1:0];
              mul_start = 1'b1; mul_a = adx_r; mul_b = t_c[ROOT_W-1:0];
              state_nxt = S_L_MX;
            end
          end else begin
            if (is_q) begin
              acc_nxt = acc_dis_c[ACCW] ? '1 : acc_dis_c[ACCW-1:0];
            end else begin
              acc_nxt = (acc_dis_c > (ACCW+1)'(LEN_MAX)) ? ACCW'(LEN_MAX)
                                                         : acc_dis_c[ACCW-1:0];
            end
            if (last_c) begin
              if (is_q) begin
                // No segment holds the target: report the last point
                px_nxt = cur_r[31:0];  py_nxt = cur_r[63:32];
                sx_nxt = prev_r[31:0]; sy_nxt = prev_r[63:32];
                ex_nxt = cur_r[31:0];  ey_nxt = cur_r[63:32];
              end else begin
                sum_nxt = (acc_dis_c > (ACCW+1)'(LEN_MAX)) ? LEN_MAX
                                                           : acc_dis_c[LEN_W-1:0];
              end
              state_nxt = S_OUT;
            end else begin
              prev_nxt  = cur_r;
              seg_nxt   = seg_r + CW'(1);
              state_nxt = S_W_NEXT;
            end
          end
        end
      end
      S_L_MX: begin
        if (mul_st.done) begin
          div_start = 1'b1; state_nxt = S_L_DX;
        end
      end
      S_L_DX: begin
        if (div_st.done) begin
          px_nxt    = dxneg_r ? prev_r[31:0] - quo[31:0] : prev_r[31:0] + quo[31:0];
          mul_start = 1'b1; mul_a = ady_r; mul_b = t_r;
          state_nxt = S_L_MY;
        end
      end
      S_L_MY: begin
        if (mul_st.done) begin
          div_start = 1'b1; state_nxt = S_L_DY;
        end
      end
      S_L_DY: begin
        if (div_st.done) begin
          py_nxt    = dyneg_r ? prev_r[63:32] - quo[31:0] : prev_r[63:32] + quo[31:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free, then load the transfer
        if (out_load) begin
          otd_nxt   = {5'b0, 9'(cnt_r), sum_r, ey_r, ex_r, sy_r, sx_r, py_r, px_r};
          otu_nxt   = status_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
    act_r <= act_nxt;   idx_r <= idx_nxt;   pt_r <= pt_nxt;     frac_r <= frac_nxt;
    mv_r <= mv_nxt;     seg_r <= seg_nxt;   tgt_r <= tgt_nxt;   acc_r <= acc_nxt;
    prev_r <= prev_nxt; cur_r <= cur_nxt;   sqx_r <= sqx_nxt;   adx_r <= adx_nxt;
    ady_r <= ady_nxt;   dxneg_r <= dxneg_nxt; dyneg_r <= dyneg_nxt;
    dis_r <= dis_nxt;   t_r <= t_nxt;       status_r <= status_nxt;
    px_r <= px_nxt;     py_r <= py_nxt;     sx_r <= sx_nxt;     sy_r <= sy_nxt;
    ex_r <= ex_nxt;     ey_r <= ey_nxt;     otd_r <= otd_nxt;   otu_r <= otu_nxt;
  end

  assign out_tdata  = otd_r;
  assign out_tuser  = otu_r;
  assign out_tvalid = ov_r;

  `PSALP_ASSERT_NOW(a_full_only_at_capacity, out_load && (status_r == ST_FULL),
    cnt_r == CW'(CAPACITY), "store full reported below capacity")
  `PSALP_ASSERT_NOW(a_query_needs_two, out_load && (status_r == ST_OK) && is_q,
    (CW+1)'(cnt_r) >= (CW+1)'(2), "query succeeded with fewer than two points")
  `PSALP_ASSERT_NOW(a_write_in_range, we,
    (CW+1)'(waddr) <= (CW+1)'(cnt_r), "memory write beyond stored points")
  `PSALP_ASSERT_NEXT(a_busy_after_accept, accept, !in_tready,
    "input ready right after a transfer")

endmodule
